// ===== rtl/core/virtio_mmio_gpu_register_block_macros.svh =====
// Assertion macros for the virtio-mmio GPU register block.
// Bodies compile to nothing when SYNTH is defined.
`ifndef VIRTIO_MMIO_GPU_REGISTER_BLOCK_MACROS_SVH
`define VIRTIO_MMIO_GPU_REGISTER_BLOCK_MACROS_SVH

`ifndef SYNTH
`define VMG_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define VMG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define VMG_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define VMG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/vmgpu_pkg.sv =====
// Types and constants shared by the virtio-mmio GPU register block.
// No dependencies.
package vmgpu_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] byte_offset;
    logic [31:0] write_data;
  } vmgpu_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault;
    logic        notify_valid;
    logic        notify_queue;
    logic        interrupt_line;
  } vmgpu_out_t;

  // Access kinds
  localparam logic [2:0] OP_WORD_READ    = 3'd0;
  localparam logic [2:0] OP_WORD_WRITE   = 3'd1;
  localparam logic [2:0] OP_NARROW_READ  = 3'd2;
  localparam logic [2:0] OP_NARROW_WRITE = 3'd3;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_ACCESS   = 2'd1;
  localparam logic [1:0] FAULT_MISALIGN = 2'd2;
  localparam logic [1:0] FAULT_ILLEGAL  = 2'd3;

  // Configuration port indexes
  localparam logic CFG_SCANOUT_COUNT = 1'b0;
  localparam logic CFG_VENDOR_IDENT  = 1'b1;

  // Register word indexes (byte offset >> 2)
  localparam logic [9:0] REG_MAGIC            = 10'h000;
  localparam logic [9:0] REG_VERSION          = 10'h001;
  localparam logic [9:0] REG_DEVICE_ID        = 10'h002;
  localparam logic [9:0] REG_VENDOR_ID        = 10'h003;
  localparam logic [9:0] REG_DEV_FEAT         = 10'h004;
  localparam logic [9:0] REG_DEV_FEAT_SEL     = 10'h005;
  localparam logic [9:0] REG_DRV_FEAT         = 10'h008;
  localparam logic [9:0] REG_DRV_FEAT_SEL     = 10'h009;
  localparam logic [9:0] REG_QUEUE_SEL        = 10'h00c;
  localparam logic [9:0] REG_QUEUE_NUM_MAX    = 10'h00d;
  localparam logic [9:0] REG_QUEUE_NUM        = 10'h00e;
  localparam logic [9:0] REG_QUEUE_READY      = 10'h011;
  localparam logic [9:0] REG_QUEUE_NOTIFY     = 10'h014;
  localparam logic [9:0] REG_IRQ_STATUS       = 10'h018;
  localparam logic [9:0] REG_IRQ_ACK          = 10'h019;
  localparam logic [9:0] REG_STATUS           = 10'h01c;
  localparam logic [9:0] REG_DESC_LO          = 10'h020;
  localparam logic [9:0] REG_DESC_HI          = 10'h021;
  localparam logic [9:0] REG_AVAIL_LO         = 10'h024;
  localparam logic [9:0] REG_AVAIL_HI         = 10'h025;
  localparam logic [9:0] REG_USED_LO          = 10'h028;
  localparam logic [9:0] REG_USED_HI          = 10'h029;
  localparam logic [9:0] REG_SHM_SEL          = 10'h02b;
  localparam logic [9:0] REG_SHM_LEN_LO       = 10'h02c;
  localparam logic [9:0] REG_SHM_LEN_HI       = 10'h02d;
  localparam logic [9:0] REG_SHM_BASE_LO      = 10'h02e;
  localparam logic [9:0] REG_SHM_BASE_HI      = 10'h02f;
  localparam logic [9:0] REG_CFG_GEN          = 10'h03f;
  localparam logic [9:0] REG_GPU_EVENTS_READ  = 10'h040;
  localparam logic [9:0] REG_GPU_EVENTS_CLEAR = 10'h041;
  localparam logic [9:0] REG_GPU_NUM_SCANOUTS = 10'h042;
  localparam logic [9:0] REG_GPU_NUM_CAPSETS  = 10'h043;

  localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE = 32'd2;
  localparam logic [31:0] DEVICE_ID_GPU = 32'd16;
  localparam logic [31:0] DEV_FEAT_LO   = 32'd2;
  localparam logic [31:0] DEV_FEAT_HI   = 32'd1;
  localparam logic [31:0] SHM_LEN_NONE  = 32'hFFFF_FFFF;

  localparam int ST_DRIVER_OK_BIT    = 2;
  localparam int ST_NEEDS_RESET_BIT  = 6;
  localparam int IRQ_CONF_CHANGE_BIT = 1;

  // Per-queue register targeted by a write
  typedef enum logic [2:0] {
    QREG_NONE,
    QREG_SIZE,
    QREG_READY,
    QREG_DESC,
    QREG_AVAIL,
    QREG_USED,
    QREG_HIGH
  } qreg_t;

  typedef struct packed {
    logic        hit;
    qreg_t       field;
    logic [31:0] data;
  } q_cmd_t;

  typedef struct packed {
    logic ready;
    logic fail;
  } q_stat_t;

endpackage

// ===== rtl/core/vmgpu_queue.sv =====
// One virtqueue's configuration: size, ring base words and ready flag.
// Checks each write against RAM bounds and the ready lock. Uses vmgpu_pkg.
module vmgpu_queue import vmgpu_pkg::*; #(
  parameter longint unsigned RAM_BYTES      = 64'd536870912,
  parameter int unsigned     MAX_QUEUE_SIZE = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    clear,
  input  q_cmd_t  cmd,
  output q_stat_t stat
);

  localparam int SW = $clog2(MAX_QUEUE_SIZE + 1);
  localparam int BW = $clog2((RAM_BYTES - 1) / 4 + 1);
  localparam int EW = ((BW > SW + 2) ? BW : SW + 2) + 2;
  localparam logic [EW-1:0] WORDS    = EW'(RAM_BYTES / 4);
  localparam logic [32:0]   RAM_LIM  = 33'(RAM_BYTES);
  localparam logic [31:0]   SIZE_MAX = 32'(MAX_QUEUE_SIZE);

  logic [SW-1:0] size_r, size_nxt;
  logic [BW-1:0] desc_r, desc_nxt;
  logic [BW-1:0] avail_r, avail_nxt;
  logic [BW-1:0] used_r, used_nxt;
  logic          ready_r, ready_nxt;

  logic [31:0]   v;
  logic          ring_bad;
  logic [BW-1:0] ring_word;
  logic          size_ok;
  logic [EW-1:0] d_end, a_end, u_end;
  logic          ring_fit;
  logic          fail;

  assign v         = cmd.data;
  assign ring_bad  = ({1'b0, v} >= RAM_LIM) || (v[1:0] != 2'b00);
  assign ring_word = ring_bad ? '0 : v[BW+1:2];
  assign size_ok   = (v != 32'd0) && (v <= SIZE_MAX);

  // Ring ends in words: descriptors 4 per entry, avail 1 + ceil(n/2), used 1 + 2n
  assign d_end = EW'(desc_r) + (EW'(size_r) << 2);
  assign a_end = EW'(avail_r) + EW'(1) + ((EW'(size_r) + EW'(1)) >> 1);
  assign u_end = EW'(used_r) + EW'(1) + (EW'(size_r) << 1);
  assign ring_fit = (size_r != '0) && (d_end <= WORDS) && (a_end <= WORDS)
                    && (u_end <= WORDS);

  always_comb begin
    size_nxt  = size_r;
    desc_nxt  = desc_r;
    avail_nxt = avail_r;
    used_nxt  = used_r;
    ready_nxt = ready_r;
    fail      = 1'b0;
    case (cmd.field)
      QREG_SIZE: begin
        if (ready_r || !size_ok) begin
          fail = 1'b1;
        end else begin
          size_nxt = v[SW-1:0];
        end
      end
      QREG_DESC: begin
        fail = ready_r || ring_bad;
        if (!ready_r) desc_nxt = ring_word;
      end
      QREG_AVAIL: begin
        fail = ready_r || ring_bad;
        if (!ready_r) avail_nxt = ring_word;
      end
      QREG_USED: begin
        fail = ready_r || ring_bad;
        if (!ready_r) used_nxt = ring_word;
      end
      QREG_HIGH: begin
        fail = ready_r || (v != 32'd0);
      end
      QREG_READY: begin
        ready_nxt = v[0] && ring_fit;
        fail      = v[0] && !ring_fit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      size_r  <= '0;
      desc_r  <= '0;
      avail_r <= '0;
      used_r  <= '0;
      ready_r <= 1'b0;
    end else if (cmd.hit) begin
      size_r  <= size_nxt;
      desc_r  <= desc_nxt;
      avail_r <= avail_nxt;
      used_r  <= used_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign stat.ready = ready_r;
  assign stat.fail  = fail;

endmodule

// ===== rtl/core/virtio_mmio_gpu_register_block.sv =====
// virtio-mmio v2 register file of a GPU device, one access per word.
// The result word is registered and appears in the cycle after the access is taken.
// Throughput: one access per cycle while out_ready is high; the result register frees as it is taken.
// Reset (rst_n low, synchronous): all device state clears, scanout count
// returns to 1 and vendor id to 0. Uses vmgpu_pkg, vmgpu_queue and the macro header.
`include "virtio_mmio_gpu_register_block_macros.svh"

module virtio_mmio_gpu_register_block import vmgpu_pkg::*; #(
  parameter int unsigned     NUM_QUEUES     = 2,
  parameter longint unsigned RAM_BYTES      = 64'd536870912,
  parameter int unsigned     MAX_QUEUE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  vmgpu_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output vmgpu_out_t  out_data
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [31:0] NQ32     = 32'(NUM_QUEUES);
  localparam logic [31:0] QMAX32   = 32'(MAX_QUEUE_SIZE);

  logic [4:0]  scanout_count_r;
  logic [31:0] vendor_ident_r;

  logic [QW-1:0] queue_select_r, queue_select_nxt;
  logic [31:0]   device_status_r, device_status_nxt;
  logic [1:0]    irq_status_r, irq_status_nxt;
  logic [31:0]   dev_feature_select_r, dev_feature_select_nxt;
  logic [31:0]   drv_feature_select_r, drv_feature_select_nxt;
  logic [31:0]   drv_features_r, drv_features_nxt;

  logic        out_valid_r;
  vmgpu_out_t  out_data_r;
  vmgpu_out_t  res;

  logic        accept;
  logic        is_write;
  logic [9:0]  word;
  logic [31:0] v;
  qreg_t       qfield;
  logic        fail;
  logic        clear;

  q_cmd_t  q_cmd  [NUM_QUEUES];
  q_stat_t q_stat [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] q_ready;
  logic          sel_fail;
  logic          notify_in_range;
  logic [QW-1:0] notify_idx;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_write = accept && (in_data.opcode == OP_WORD_WRITE);
  assign word     = in_data.byte_offset[11:2];
  assign v        = in_data.write_data;

  always_comb begin
    case (word)
      REG_QUEUE_NUM:   qfield = QREG_SIZE;
      REG_QUEUE_READY: qfield = QREG_READY;
      REG_DESC_LO:     qfield = QREG_DESC;
      REG_AVAIL_LO:    qfield = QREG_AVAIL;
      REG_USED_LO:     qfield = QREG_USED;
      REG_DESC_HI,
      REG_AVAIL_HI,
      REG_USED_HI:     qfield = QREG_HIGH;
      default:         qfield = QREG_NONE;
    endcase
  end

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_queue
    assign q_cmd[i].hit   = is_write && (queue_select_r == QW'(i));
    assign q_cmd[i].field = qfield;
    assign q_cmd[i].data  = v;
    assign q_ready[i]     = q_stat[i].ready;

    vmgpu_queue #(
      .RAM_BYTES      (RAM_BYTES),
      .MAX_QUEUE_SIZE (MAX_QUEUE_SIZE)
    ) u_queue (
      .clk   (clk),
      .rst_n (rst_n),
      .clear (clear && accept),
      .cmd   (q_cmd[i]),
      .stat  (q_stat[i])
    );
  end

  assign sel_fail        = q_stat[queue_select_r].fail;
  assign notify_in_range = v < NQ32;
  assign notify_idx      = v[QW-1:0];

  always_comb begin
    queue_select_nxt       = queue_select_r;
    device_status_nxt      = device_status_r;
    irq_status_nxt         = irq_status_r;
    dev_feature_select_nxt = dev_feature_select_r;
    drv_feature_select_nxt = drv_feature_select_r;
    drv_features_nxt       = drv_features_r;
    fail                   = 1'b0;
    clear                  = 1'b0;
    res                    = '0;

    case (in_data.opcode)
      OP_WORD_READ: begin
        case (word)
          REG_MAGIC:            res.read_data = MAGIC_VALUE;
          REG_VERSION:          res.read_data = VERSION_VALUE;
          REG_DEVICE_ID:        res.read_data = DEVICE_ID_GPU;
          REG_VENDOR_ID:        res.read_data = vendor_ident_r;
          REG_DEV_FEAT: begin
            if (dev_feature_select_r == 32'd0) begin
              res.read_data = DEV_FEAT_LO;
            end else if (dev_feature_select_r == 32'd1) begin
              res.read_data = DEV_FEAT_HI;
            end
          end
          REG_QUEUE_NUM_MAX:    res.read_data = QMAX32;
          REG_QUEUE_READY:      res.read_data = {31'd0, q_ready[queue_select_r]};
          REG_IRQ_STATUS:       res.read_data = {30'd0, irq_status_r};
          REG_STATUS:           res.read_data = device_status_r;
          REG_SHM_LEN_LO,
          REG_SHM_LEN_HI:       res.read_data = SHM_LEN_NONE;
          REG_SHM_BASE_LO,
          REG_SHM_BASE_HI,
          REG_CFG_GEN,
          REG_GPU_EVENTS_READ,
          REG_GPU_NUM_CAPSETS:  res.read_data = 32'd0;
          REG_GPU_NUM_SCANOUTS: res.read_data = {27'd0, scanout_count_r};
          default:              res.fault = FAULT_ACCESS;
        endcase
      end
      OP_WORD_WRITE: begin
        case (word)
          REG_DEV_FEAT_SEL: dev_feature_select_nxt = v;
          REG_DRV_FEAT: begin
            if (drv_feature_select_r == 32'd0) drv_features_nxt = v;
          end
          REG_DRV_FEAT_SEL: drv_feature_select_nxt = v;
          REG_QUEUE_SEL: begin
            if (v < NQ32) begin
              queue_select_nxt = v[QW-1:0];
            end else begin
              fail = 1'b1;
            end
          end
          REG_QUEUE_NUM,
          REG_QUEUE_READY,
          REG_DESC_LO,
          REG_DESC_HI,
          REG_AVAIL_LO,
          REG_AVAIL_HI,
          REG_USED_LO,
          REG_USED_HI: fail = sel_fail;
          REG_QUEUE_NOTIFY: begin
            // drop an in-range notify silently while the device waits for reset
            if (!notify_in_range) begin
              fail = 1'b1;
            end else if (!device_status_r[ST_NEEDS_RESET_BIT]) begin
              if (device_status_r[ST_DRIVER_OK_BIT] && q_ready[notify_idx]) begin
                res.notify_valid = 1'b1;
                res.notify_queue = v[0];
              end else begin
                fail = 1'b1;
              end
            end
          end
          REG_IRQ_ACK: irq_status_nxt = irq_status_r & ~v[1:0];
          REG_STATUS: begin
            if (v == 32'd0) begin
              clear = 1'b1;
            end else begin
              device_status_nxt = device_status_r | v;
            end
          end
          REG_SHM_SEL,
          REG_GPU_EVENTS_CLEAR: begin
          end
          default: res.fault = FAULT_ACCESS;
        endcase
      end
      OP_NARROW_READ,
      OP_NARROW_WRITE: res.fault = FAULT_MISALIGN;
      default:         res.fault = FAULT_ILLEGAL;
    endcase

    if (fail) begin
      device_status_nxt[ST_NEEDS_RESET_BIT] = 1'b1;
      if (device_status_nxt[ST_DRIVER_OK_BIT]) begin
        irq_status_nxt[IRQ_CONF_CHANGE_BIT] = 1'b1;
      end
    end

    if (clear) begin
      queue_select_nxt       = '0;
      device_status_nxt      = '0;
      irq_status_nxt         = '0;
      dev_feature_select_nxt = '0;
      drv_feature_select_nxt = '0;
      drv_features_nxt       = '0;
    end

    res.interrupt_line = (irq_status_nxt != 2'b00);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_select_r       <= '0;
      device_status_r      <= '0;
      irq_status_r         <= '0;
      dev_feature_select_r <= '0;
      drv_feature_select_r <= '0;
      drv_features_r       <= '0;
    end else if (accept) begin
      queue_select_r       <= queue_select_nxt;
      device_status_r      <= device_status_nxt;
      irq_status_r         <= irq_status_nxt;
      dev_feature_select_r <= dev_feature_select_nxt;
      drv_feature_select_r <= drv_feature_select_nxt;
      drv_features_r       <= drv_features_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanout_count_r <= 5'd1;
      vendor_ident_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCANOUT_COUNT: scanout_count_r <= cfg_wdata[4:0];
        CFG_VENDOR_IDENT:  vendor_ident_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Result register: load on accept, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VMG_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, accept, out_valid_r, "accepted access produced no result word")
  `VMG_ASSERT_ALWAYS(a_irq_line_matches, clk, rst_n, !out_valid_r || (out_data_r.interrupt_line == (irq_status_r != 2'b00)), "interrupt line disagrees with interrupt status")
  `VMG_ASSERT_ALWAYS(a_conf_irq_needs_reset, clk, rst_n, !irq_status_r[IRQ_CONF_CHANGE_BIT] || device_status_r[ST_NEEDS_RESET_BIT], "config change interrupt without needs reset")

endmodule
